// ===== rtl/dcke_pkg.sv =====
// Shared types and constants for the DER certificate key extractor.
// Used by the front, queue, walker and top-level modules; no dependencies.
`default_nettype none

package dcke_pkg;

   localparam logic [7:0] SHORT_LIMIT = 8'h80;
   localparam logic [7:0] LONG2_FORM  = 8'h82;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_SHORT    = 2'd1;
   localparam logic [1:0] STATUS_FORM     = 2'd2;
   localparam logic [1:0] STATUS_OVERRUN  = 2'd3;

   localparam logic [3:0] STEP_CERT      = 4'd0;
   localparam logic [3:0] STEP_TBS       = 4'd1;
   localparam logic [3:0] STEP_SPKI      = 4'd8;
   localparam logic [3:0] STEP_KEY       = 4'd10;

   typedef struct packed {
      logic [7:0]  cert_byte;
      logic        first_byte;
      logic [15:0] cert_length;
      logic        short_form;
      logic        long2_form;
      logic        length_zero;
   } item_type;

endpackage

`default_nettype wire

// ===== rtl/der_certificate_key_extractor.sv =====
// A key byte passes the front register, a queue slot and the result register
// before reaching the rsp_ ports. Throughput: one certificate byte per cycle, sustained, set by the walker
// consuming one queued byte each cycle while the result register is free.
// Reset: synchronous, active high; the walker returns to idle and waits for a first byte.
`default_nettype none

module der_certificate_key_extractor import dcke_pkg::*; #(
   parameter int LENGTH_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_cert_byte,
   input  wire logic        req_first_byte,
   input  wire logic [15:0] req_cert_length,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_key_byte,
   output logic             rsp_key_last,
   output logic             rsp_key_empty,
   output logic [15:0]      rsp_key_length,
   output logic [1:0]       rsp_parse_status
);

   logic     front_valid, front_ready;
   item_type front_item;
   logic     queue_valid, queue_ready;
   item_type queue_item;

   dcke_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cert_byte   (req_cert_byte),
      .req_first_byte  (req_first_byte),
      .req_cert_length (req_cert_length),
      .item_valid      (front_valid),
      .item_ready      (front_ready),
      .item            (front_item)
   );

   dcke_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_item   (queue_item)
   );

   dcke_walker #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_walker (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (queue_valid),
      .item_ready       (queue_ready),
      .item             (queue_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_key_byte     (rsp_key_byte),
      .rsp_key_last     (rsp_key_last),
      .rsp_key_empty    (rsp_key_empty),
      .rsp_key_length   (rsp_key_length),
      .rsp_parse_status (rsp_parse_status)
   );

endmodule

`default_nettype wire

// ===== rtl/dcke_front.sv =====
// Front stage: registers each incoming certificate byte and classifies it.
// Depends on dcke_pkg for the item record and the length-form constants.
`default_nettype none

module dcke_front import dcke_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_cert_byte,
   input  wire logic        req_first_byte,
   input  wire logic [15:0] req_cert_length,
   output logic             item_valid,
   input  wire logic        item_ready,
   output item_type         item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take;

   assign req_stall = valid_ff && !item_ready;
   assign take      = req_valid && !req_stall;

   always_comb begin
      item_in.cert_byte   = req_cert_byte;
      item_in.first_byte  = req_first_byte;
      item_in.cert_length = req_cert_length;
      item_in.short_form  = (req_cert_byte < SHORT_LIMIT);
      item_in.long2_form  = (req_cert_byte == LONG2_FORM);
      item_in.length_zero = (req_cert_length == 16'd0);
      if (take) begin
         valid_in = 1'b1;
      end else if (item_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ===== rtl/dcke_queue.sv =====
// Two-entry queue between the classifying front and the walker.
// Depends on dcke_pkg for the item record.
`default_nettype none

module dcke_queue import dcke_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push_valid,
   output logic      push_ready,
   input  item_type  push_item,
   output logic      pop_valid,
   input  wire logic pop_ready,
   output item_type  pop_item
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2) else $error("queue count out of range");

   a_pointer_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

   a_pop_follows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop && count_ff == 2'd1) |=> !push_ready)
      else $error("queue did not fill");

endmodule

`default_nettype wire

// ===== rtl/dcke_walker.sv =====
// Back part: walks the fixed DER path and emits the public key bytes.
// Depends on dcke_pkg for the item record, status codes and path steps.
`default_nettype none

module dcke_walker import dcke_pkg::*; #(
   parameter int LENGTH_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        item_valid,
   output logic             item_ready,
   input  item_type         item,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_key_byte,
   output logic             rsp_key_last,
   output logic             rsp_key_empty,
   output logic [15:0]      rsp_key_length,
   output logic [1:0]       rsp_parse_status
);

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_TAG   = 3'd1;
   localparam logic [2:0] PH_LEN1  = 3'd2;
   localparam logic [2:0] PH_LENHI = 3'd3;
   localparam logic [2:0] PH_LENLO = 3'd4;
   localparam logic [2:0] PH_SKIP  = 3'd5;
   localparam logic [2:0] PH_KEY   = 3'd6;

   localparam logic [LENGTH_BITS-1:0] ONE = LENGTH_BITS'(1);
   localparam logic [LENGTH_BITS-1:0] TWO = LENGTH_BITS'(2);

   logic [2:0]             phase_ff, phase_in;
   logic [3:0]             step_ff, step_in;
   logic [LENGTH_BITS-1:0] region_ff, region_in;
   logic [LENGTH_BITS-1:0] body_ff, body_in;
   logic [7:0]             len_high_ff, len_high_in;
   logic [15:0]            key_total_ff, key_total_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             key_byte_ff, key_byte_in;
   logic                   key_last_ff, key_last_in;
   logic                   key_empty_ff, key_empty_in;
   logic [15:0]            key_length_ff, key_length_in;
   logic [1:0]             status_ff, status_in;

   logic                   take;
   logic                   emit;
   logic                   hdr_go;
   logic [15:0]            hdr_len;
   logic [LENGTH_BITS-1:0] hdr_len_ext;
   logic                   enter_step;

   assign item_ready = !rsp_valid_ff || !rsp_stall;
   assign take       = item_valid && item_ready;

   always_comb begin
      phase_in      = phase_ff;
      step_in       = step_ff;
      region_in     = region_ff;
      body_in       = body_ff;
      len_high_in   = len_high_ff;
      key_total_in  = key_total_ff;
      emit          = 1'b0;
      key_byte_in   = 8'd0;
      key_last_in   = 1'b0;
      key_empty_in  = 1'b0;
      key_length_in = 16'd0;
      status_in     = STATUS_OK;
      hdr_go        = 1'b0;
      hdr_len       = 16'd0;

      if (item.first_byte) begin
         step_in      = STEP_CERT;
         body_in      = '0;
         len_high_in  = 8'd0;
         key_total_in = 16'd0;
         region_in    = LENGTH_BITS'(item.cert_length);
         phase_in     = item.length_zero ? PH_IDLE : PH_TAG;
      end

      unique case (phase_in)
         PH_TAG: begin
            if (region_in < TWO) begin
               phase_in  = PH_IDLE;
               emit      = 1'b1;
               status_in = STATUS_SHORT;
            end else begin
               region_in = region_in - ONE;
               phase_in  = PH_LEN1;
            end
         end
         PH_LEN1: begin
            region_in = region_in - ONE;
            if (item.short_form) begin
               hdr_go  = 1'b1;
               hdr_len = {8'd0, item.cert_byte};
            end else if (!item.long2_form) begin
               phase_in  = PH_IDLE;
               emit      = 1'b1;
               status_in = STATUS_FORM;
            end else if (region_in < TWO) begin
               phase_in  = PH_IDLE;
               emit      = 1'b1;
               status_in = STATUS_SHORT;
            end else begin
               phase_in = PH_LENHI;
            end
         end
         PH_LENHI: begin
            region_in   = region_in - ONE;
            len_high_in = item.cert_byte;
            phase_in    = PH_LENLO;
         end
         PH_LENLO: begin
            region_in = region_in - ONE;
            hdr_go    = 1'b1;
            hdr_len   = {len_high_in, item.cert_byte};
         end
         PH_SKIP: begin
            body_in = body_in - ONE;
            if (body_in == '0) begin
               step_in  = step_in + 4'd1;
               phase_in = PH_TAG;
            end
         end
         PH_KEY: begin
            body_in       = body_in - ONE;
            emit          = 1'b1;
            key_byte_in   = item.cert_byte;
            key_length_in = key_total_in;
            if (body_in == '0) begin
               phase_in    = PH_IDLE;
               key_last_in = 1'b1;
            end
         end
         default: begin
         end
      endcase

      hdr_len_ext = LENGTH_BITS'(hdr_len);
      enter_step  = (step_in == STEP_CERT) || (step_in == STEP_TBS)
                 || (step_in == STEP_SPKI) || (step_in == STEP_KEY);

      if (hdr_go) begin
         if (hdr_len_ext > region_in) begin
            phase_in  = PH_IDLE;
            emit      = 1'b1;
            status_in = STATUS_OVERRUN;
         end else if (enter_step) begin
            region_in = hdr_len_ext;
            if (step_in == STEP_KEY) begin
               key_total_in = hdr_len;
               if (hdr_len == 16'd0) begin
                  phase_in     = PH_IDLE;
                  emit         = 1'b1;
                  key_empty_in = 1'b1;
               end else begin
                  body_in  = hdr_len_ext;
                  phase_in = PH_KEY;
               end
            end else begin
               step_in  = step_in + 4'd1;
               phase_in = PH_TAG;
            end
         end else begin
            region_in = region_in - hdr_len_ext;
            if (hdr_len == 16'd0) begin
               step_in  = step_in + 4'd1;
               phase_in = PH_TAG;
            end else begin
               body_in  = hdr_len_ext;
               phase_in = PH_SKIP;
            end
         end
      end

      if (emit && status_in != STATUS_OK) begin
         key_last_in = 1'b1;
      end
      if (emit && key_empty_in) begin
         key_last_in = 1'b1;
      end

      if (take && emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         step_ff      <= STEP_CERT;
         region_ff    <= '0;
         body_ff      <= '0;
         len_high_ff  <= 8'd0;
         key_total_ff <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            phase_ff     <= phase_in;
            step_ff      <= step_in;
            region_ff    <= region_in;
            body_ff      <= body_in;
            len_high_ff  <= len_high_in;
            key_total_ff <= key_total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) begin
         key_byte_ff   <= key_byte_in;
         key_last_ff   <= key_last_in;
         key_empty_ff  <= key_empty_in;
         key_length_ff <= key_length_in;
         status_ff     <= status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_key_byte     = key_byte_ff;
   assign rsp_key_last     = key_last_ff;
   assign rsp_key_empty    = key_empty_ff;
   assign rsp_key_length   = key_length_ff;
   assign rsp_parse_status = status_ff;

   a_key_body_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_KEY |-> body_ff != '0)
      else $error("key phase with no body bytes left");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_KEY) else $error("path step past the key item");

   a_error_idles: assert property (@(posedge clock) disable iff (reset)
      (take && emit && status_in != STATUS_OK) |=> phase_ff == PH_IDLE)
      else $error("walker did not stop after a parse error");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && key_empty_ff) |-> key_last_ff)
      else $error("empty key result not flagged last");

endmodule

`default_nettype wire
